/* rtl/core/fln_pkg.sv */
package fln_pkg;

  // fixed field widths
  localparam int POS_W     = 24;
  localparam int DIFF_W    = POS_W + 1;
  localparam int GAIN_W    = 24;
  localparam int THR_W     = 23;
  localparam int EDGE_W    = 8;
  localparam int SW_W      = 12;
  localparam int ACC_W     = 40;
  localparam int SUM_W     = ACC_W + 1;
  localparam int FRAC_BITS = 8;
  localparam int MAX_EDGES = 255;

  // shared multiplier and divider widths
  localparam int MUL_W  = DIFF_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int RNUM_W = DIFF_W + GAIN_W;
  localparam int NUM_W  = RNUM_W + FRAC_BITS;
  localparam int DEN_W  = PROD_W;
  localparam int QUO_W  = 32;
  localparam int CNT_W  = $clog2(QUO_W);

  // stream and config port widths
  localparam int S_TDATA_W  = 64;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register reset values
  localparam logic [GAIN_W-1:0]       GAIN_RST   = 24'd57600;
  localparam logic [THR_W-1:0]        THR_RST    = 23'd1024;
  localparam logic [THR_W-1:0]        MARGIN_RST = 23'd25600;
  localparam logic signed [POS_W-1:0] LOW_RST    = -24'sd51200;
  localparam logic signed [POS_W-1:0] HIGH_RST   = 24'sd51200;
  localparam logic [SW_W-1:0]         SW_RST     = 12'd10;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_OTHER  = 2'd1,
    CMD_NEIGH  = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 3'd0,
    REG_THR    = 3'd1,
    REG_MARGIN = 3'd2,
    REG_LEFT   = 3'd3,
    REG_RIGHT  = 3'd4,
    REG_TOP    = 3'd5,
    REG_BOTTOM = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_GNX,
    ST_GNY,
    ST_GOX,
    ST_WAITX,
    ST_GOY,
    ST_WAITY,
    ST_FIN,
    ST_CLAMP
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // accumulator add with saturation at the 40-bit limits
  function automatic logic signed [ACC_W-1:0] acc_sat(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [QUO_W:0]   term
  );
    logic signed [SUM_W-1:0] s;
    logic signed [ACC_W-1:0] r;
    s = {acc[ACC_W-1], acc} + {{(SUM_W - QUO_W - 1){term[QUO_W]}}, term};
    if (s[SUM_W-1] != s[ACC_W-1]) begin
      r = s[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/fln_mul.sv */
module fln_mul (
  input  logic                         clk,
  input  logic [fln_pkg::MUL_W-1:0]    a,
  input  logic [fln_pkg::MUL_W-1:0]    b,
  output logic [fln_pkg::PROD_W-1:0]   p
);

  // one registered unsigned product per cycle
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* rtl/core/fln_div.sv */
module fln_div (
  input  logic              clk,
  input  logic              rst,
  input  fln_pkg::div_req_t req,
  output fln_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [fln_pkg::CNT_W-1:0]     cnt;
  logic [fln_pkg::DEN_W-1:0]     rem;
  logic [fln_pkg::DEN_W-1:0]     den_r;
  logic [fln_pkg::QUO_W-1:0]     quo_sr;
  logic [fln_pkg::DEN_W:0]       trial;
  logic [fln_pkg::DEN_W:0]       diff;
  logic                          ge;

  // restoring division, one quotient bit per cycle; the upper dividend bits
  // are known to stay below the divisor, so only the low bits are shifted in
  assign trial = {rem, quo_sr[fln_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == fln_pkg::CNT_W'(fln_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem    <= fln_pkg::DEN_W'(req.num[fln_pkg::NUM_W-1:fln_pkg::QUO_W]);
      quo_sr <= req.num[fln_pkg::QUO_W-1:0];
      den_r  <= req.den;
    end else if (busy) begin
      rem    <= ge ? diff[fln_pkg::DEN_W-1:0] : trial[fln_pkg::DEN_W-1:0];
      quo_sr <= {quo_sr[fln_pkg::QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo_sr;

endmodule

/* rtl/core/force_layout_node_step.sv */
// force layout node step: next position of one graph node in a
// spring-electrical layout, all coordinates signed Q16.8
//
// input stream: a begin transaction loads the own position, edge count and
// pinned flag and clears the force sums; each other-node transaction adds a
// repulsion term, each neighbour transaction subtracts a spring term; a
// finish transaction yields one output transaction with the clamped position
// and a moved flag. no other command gives an output transaction
//
// s_tready drops while a transaction is worked on; a begin transaction
// takes no further step, and a finish also waits out any output stall.
// an other-node item uses one shared 25x25 multiplier four times in a row
// and one shared radix-2 divider once per axis; the neighbour item needs
// only the two divides
//
// the output register holds one result; the block keeps taking input while
// it waits, and a later finish waits in its last step until m_tready frees
// the register. reset (synchronous, rst high) restores the default scene,
// gain, threshold and margin, clears position and force, spring weight 10
module force_layout_node_step (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pos_x [23:0], pos_y [47:24], edge_count [55:48], pinned [56], zero fill
  input  logic [fln_pkg::S_TDATA_W-1:0]    s_tdata,
  // cmd [1:0]
  input  logic [fln_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // new_x [23:0], new_y [47:24], moved [48], zero fill
  output logic [fln_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                             cfg_we,
  input  logic [fln_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fln_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int POS_W  = fln_pkg::POS_W;
  localparam int DIFF_W = fln_pkg::DIFF_W;
  localparam int SUM_W  = fln_pkg::SUM_W;
  localparam int ACC_W  = fln_pkg::ACC_W;
  localparam int THR_W  = fln_pkg::THR_W;
  localparam int QUO_W  = fln_pkg::QUO_W;

  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(8388608);

  // configuration registers
  logic [fln_pkg::GAIN_W-1:0] gain;
  logic [THR_W-1:0]           stop_thr;
  logic [THR_W-1:0]           margin;
  logic signed [POS_W-1:0]    scene_left;
  logic signed [POS_W-1:0]    scene_right;
  logic signed [POS_W-1:0]    scene_top;
  logic signed [POS_W-1:0]    scene_bottom;

  // node state
  logic signed [POS_W-1:0]    own_x;
  logic signed [POS_W-1:0]    own_y;
  logic signed [ACC_W-1:0]    force_x;
  logic signed [ACC_W-1:0]    force_y;
  logic [fln_pkg::SW_W-1:0]   spring_weight;
  logic                       hold_flag;

  fln_pkg::state_t            state;
  fln_pkg::state_t            state_next;

  // per-item working registers
  logic [DIFF_W-1:0]          mag_x;
  logic [DIFF_W-1:0]          mag_y;
  logic                       neg_x;
  logic                       neg_y;
  logic                       repulse;
  logic [fln_pkg::PROD_W-1:0] lsum;
  logic [fln_pkg::RNUM_W-1:0] num_x;
  logic [fln_pkg::RNUM_W-1:0] num_y;
  logic signed [SUM_W-1:0]    sum_x;
  logic signed [SUM_W-1:0]    sum_y;
  logic signed [DIFF_W-1:0]   lo_x;
  logic signed [DIFF_W-1:0]   hi_x;
  logic signed [DIFF_W-1:0]   lo_y;
  logic signed [DIFF_W-1:0]   hi_y;

  // output register
  logic signed [POS_W-1:0]    out_x;
  logic signed [POS_W-1:0]    out_y;
  logic                       out_moved;
  logic                       out_load;

  // input fields
  fln_pkg::cmd_t              in_cmd;
  logic signed [POS_W-1:0]    in_x;
  logic signed [POS_W-1:0]    in_y;
  logic [fln_pkg::EDGE_W-1:0] in_edges;
  logic                       in_pinned;
  logic                       in_fire;

  logic signed [DIFF_W-1:0]   diff_x;
  logic signed [DIFF_W-1:0]   diff_y;
  logic [fln_pkg::SW_W-1:0]   edge_sat;
  logic [fln_pkg::SW_W-1:0]   weight_new;

  // shared units
  logic [fln_pkg::MUL_W-1:0]  mul_a;
  logic [fln_pkg::MUL_W-1:0]  mul_b;
  logic [fln_pkg::PROD_W-1:0] prod;
  fln_pkg::div_req_t          div_req;
  fln_pkg::div_rsp_t          div_rsp;

  logic                       term_neg;
  logic signed [QUO_W:0]      term;
  logic                       still;
  logic signed [SUM_W-1:0]    thr_w;
  logic signed [SUM_W-1:0]    fx_w;
  logic signed [SUM_W-1:0]    fy_w;
  logic signed [SUM_W-1:0]    cx;
  logic signed [SUM_W-1:0]    cy;
  logic signed [POS_W-1:0]    res_x;
  logic signed [POS_W-1:0]    res_y;

  assign in_cmd    = fln_pkg::cmd_t'(s_tuser);
  assign in_x      = s_tdata[23:0];
  assign in_y      = s_tdata[47:24];
  assign in_edges  = s_tdata[55:48];
  assign in_pinned = s_tdata[56];
  assign in_fire   = s_tvalid && s_tready;

  // offset from the other node, taken against the current own position
  assign diff_x = {own_x[POS_W-1], own_x} - {in_x[POS_W-1], in_x};
  assign diff_y = {own_y[POS_W-1], own_y} - {in_y[POS_W-1], in_y};

  // spring weight (edges + 1) * 10 with the edge count capped
  always_comb begin
    edge_sat = fln_pkg::SW_W'(in_edges);
    if (edge_sat > fln_pkg::SW_W'(fln_pkg::MAX_EDGES)) begin
      edge_sat = fln_pkg::SW_W'(fln_pkg::MAX_EDGES);
    end
    weight_new = fln_pkg::SW_W'((edge_sat + 1'b1) * 4'd10);
  end

  fln_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  fln_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer: squares and gain products go through the multiplier one per
  // cycle, then one divide per axis
  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    mul_a       = mag_x;
    mul_b       = mag_x;
    div_req     = '0;
    out_load    = 1'b0;
    case (state)
      fln_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (in_cmd)
            fln_pkg::CMD_OTHER:  if (!hold_flag) state_next = fln_pkg::ST_SQX;
            fln_pkg::CMD_NEIGH:  if (!hold_flag) state_next = fln_pkg::ST_GOX;
            fln_pkg::CMD_FINISH: state_next = fln_pkg::ST_FIN;
            default: ;
          endcase
        end
      end
      fln_pkg::ST_SQX: begin
        state_next = fln_pkg::ST_SQY;
      end
      fln_pkg::ST_SQY: begin
        mul_a      = mag_y;
        mul_b      = mag_y;
        state_next = fln_pkg::ST_GNX;
      end
      fln_pkg::ST_GNX: begin
        mul_b      = fln_pkg::MUL_W'(gain);
        state_next = fln_pkg::ST_GNY;
      end
      fln_pkg::ST_GNY: begin
        mul_a      = mag_y;
        mul_b      = fln_pkg::MUL_W'(gain);
        // coincident positions add nothing
        state_next = (lsum == '0) ? fln_pkg::ST_IDLE : fln_pkg::ST_GOX;
      end
      fln_pkg::ST_GOX: begin
        div_req.start = 1'b1;
        div_req.num   = repulse ? {num_x, {fln_pkg::FRAC_BITS{1'b0}}}
                                : fln_pkg::NUM_W'(mag_x);
        div_req.den   = repulse ? lsum : fln_pkg::DEN_W'(spring_weight);
        state_next    = fln_pkg::ST_WAITX;
      end
      fln_pkg::ST_WAITX: begin
        if (div_rsp.done) state_next = fln_pkg::ST_GOY;
      end
      fln_pkg::ST_GOY: begin
        div_req.start = 1'b1;
        div_req.num   = repulse ? {num_y, {fln_pkg::FRAC_BITS{1'b0}}}
                                : fln_pkg::NUM_W'(mag_y);
        div_req.den   = repulse ? lsum : fln_pkg::DEN_W'(spring_weight);
        state_next    = fln_pkg::ST_WAITY;
      end
      fln_pkg::ST_WAITY: begin
        if (div_rsp.done) state_next = fln_pkg::ST_IDLE;
      end
      fln_pkg::ST_FIN: begin
        state_next = fln_pkg::ST_CLAMP;
      end
      fln_pkg::ST_CLAMP: begin
        // wait for a free output register
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = fln_pkg::ST_IDLE;
        end
      end
      default: state_next = fln_pkg::ST_IDLE;
    endcase
  end

  // signed force term: repulsion pushes along d, spring pulls against it
  always_comb begin
    if (state == fln_pkg::ST_WAITY) begin
      term_neg = repulse ? neg_y : !neg_y;
    end else begin
      term_neg = repulse ? neg_x : !neg_x;
    end
    term = term_neg ? -{1'b0, div_rsp.quo} : {1'b0, div_rsp.quo};
  end

  // finish: drop small motion, add force to the own position
  assign thr_w = SUM_W'(stop_thr);
  assign fx_w  = {force_x[ACC_W-1], force_x};
  assign fy_w  = {force_y[ACC_W-1], force_y};
  assign still = (fx_w > -thr_w) && (fx_w < thr_w) && (fy_w > -thr_w) && (fy_w < thr_w);

  // clamp: low bound first, then high bound, then the 24-bit range
  always_comb begin
    cx = sum_x;
    if (cx < SUM_W'(lo_x)) cx = SUM_W'(lo_x);
    if (cx > SUM_W'(hi_x)) cx = SUM_W'(hi_x);
    if (cx > POS_MAX) cx = POS_MAX;
    if (cx < POS_MIN) cx = POS_MIN;
    cy = sum_y;
    if (cy < SUM_W'(lo_y)) cy = SUM_W'(lo_y);
    if (cy > SUM_W'(hi_y)) cy = SUM_W'(hi_y);
    if (cy > POS_MAX) cy = POS_MAX;
    if (cy < POS_MIN) cy = POS_MIN;
    // a pinned node stays where it is
    res_x = hold_flag ? own_x : cx[POS_W-1:0];
    res_y = hold_flag ? own_y : cy[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fln_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration and node state
  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= fln_pkg::GAIN_RST;
      stop_thr      <= fln_pkg::THR_RST;
      margin        <= fln_pkg::MARGIN_RST;
      scene_left    <= fln_pkg::LOW_RST;
      scene_right   <= fln_pkg::HIGH_RST;
      scene_top     <= fln_pkg::LOW_RST;
      scene_bottom  <= fln_pkg::HIGH_RST;
      own_x         <= '0;
      own_y         <= '0;
      force_x       <= '0;
      force_y       <= '0;
      spring_weight <= fln_pkg::SW_RST;
      hold_flag     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (fln_pkg::cfg_reg_t'(cfg_index))
          fln_pkg::REG_GAIN:   gain         <= cfg_data;
          fln_pkg::REG_THR:    stop_thr     <= cfg_data[THR_W-1:0];
          fln_pkg::REG_MARGIN: margin       <= cfg_data[THR_W-1:0];
          fln_pkg::REG_LEFT:   scene_left   <= cfg_data;
          fln_pkg::REG_RIGHT:  scene_right  <= cfg_data;
          fln_pkg::REG_TOP:    scene_top    <= cfg_data;
          fln_pkg::REG_BOTTOM: scene_bottom <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && in_cmd == fln_pkg::CMD_BEGIN) begin
        own_x         <= in_x;
        own_y         <= in_y;
        force_x       <= '0;
        force_y       <= '0;
        spring_weight <= weight_new;
        hold_flag     <= in_pinned;
      end
      if (state == fln_pkg::ST_WAITX && div_rsp.done) begin
        force_x <= fln_pkg::acc_sat(force_x, term);
      end
      if (state == fln_pkg::ST_WAITY && div_rsp.done) begin
        force_y <= fln_pkg::acc_sat(force_y, term);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag_x   <= diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
      mag_y   <= diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
      neg_x   <= diff_x[DIFF_W-1];
      neg_y   <= diff_y[DIFF_W-1];
      repulse <= (in_cmd == fln_pkg::CMD_OTHER);
    end
    case (state)
      fln_pkg::ST_SQY: lsum  <= prod;
      fln_pkg::ST_GNX: lsum  <= lsum + prod;
      fln_pkg::ST_GNY: num_x <= prod[fln_pkg::RNUM_W-1:0];
      fln_pkg::ST_GOX: num_y <= prod[fln_pkg::RNUM_W-1:0];
      fln_pkg::ST_FIN: begin
        sum_x <= SUM_W'(own_x) + (still ? '0 : fx_w);
        sum_y <= SUM_W'(own_y) + (still ? '0 : fy_w);
        lo_x  <= DIFF_W'(scene_left)   + DIFF_W'(margin);
        hi_x  <= DIFF_W'(scene_right)  - DIFF_W'(margin);
        lo_y  <= DIFF_W'(scene_top)    + DIFF_W'(margin);
        hi_y  <= DIFF_W'(scene_bottom) - DIFF_W'(margin);
      end
      default: ;
    endcase
    if (out_load) begin
      out_x     <= res_x;
      out_y     <= res_y;
      out_moved <= (res_x != own_x) || (res_y != own_y);
    end
  end

  assign m_tdata = {7'b0, out_moved, out_y, out_x};

`ifndef SYNTHESIS
  // a pinned node ignores other and neighbour transactions
  a_pinned_skip: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && hold_flag &&
     (s_tuser == fln_pkg::CMD_OTHER || s_tuser == fln_pkg::CMD_NEIGH))
    |=> state == fln_pkg::ST_IDLE)
    else $error("pinned node started force work");

  // divider results only arrive while the sequencer waits for them
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == fln_pkg::ST_WAITX || state == fln_pkg::ST_WAITY))
    else $error("divider done outside a wait step");

  // a finish transaction holds off input in its finish step
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == fln_pkg::CMD_FINISH) |=> !s_tready)
    else $error("input taken during finish");

  // a pinned node reports no motion
  a_pinned_still: assert property (@(posedge clk) disable iff (rst)
    (state == fln_pkg::ST_CLAMP && hold_flag && (!m_tvalid || m_tready))
    |=> m_tvalid && !m_tdata[48])
    else $error("pinned node reported as moved");
`endif

endmodule
